/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the triangle split pointer scan.
// Each macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/stps_pkg.sv */
// Shared types and constants for the lower/upper split pointer scan.
// No dependencies; used by stps_classify and sparse_triangle_split_pointers.
package stps_pkg;

  localparam int CountBitsDefault = 31;
  localparam int FIELD_W          = 31;
  localparam int CFG_IDX_W        = 3;
  localparam int IN_DATA_W        = 32;
  localparam int IN_USER_W        = 2;
  localparam int OUT_DATA_W       = 160;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION_COLUMN    = 3'd0,
    REG_INDEX_BASE          = 3'd1,
    REG_LOWER_DIAG_NON_UNIT = 3'd2,
    REG_UPPER_DIAG_NON_UNIT = 3'd3,
    REG_LOWER_BASE          = 3'd4,
    REG_UPPER_BASE          = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic direction_column;
    logic index_base;
    logic lower_diag_non_unit;
    logic upper_diag_non_unit;
    logic lower_base;
    logic upper_base;
  } cfg_t;

  // Which running count an entry bumps; at most one bit is set.
  typedef struct packed {
    logic inc_lower;
    logic inc_upper;
  } cls_t;

endpackage

/* rtl/sparse_triangle_split_pointers.sv */
// Top level of the lower/upper split pointer scan for compressed sparse matrices.
// Depends on stps_pkg, stps_classify and assert_macros.svh.
//
//   Channel   Dir  Handshake                    Carries
//   s_axis    in   s_axis_tvalid/s_axis_tready  one entry or empty-row marker
//   m_axis    out  m_axis_tvalid/m_axis_tready  row end pointers and totals
//   cfg       in   cfg_valid/cfg_ready          one 1-bit register write
//
// Each input beat is captured in an input register, then classified and
// counted by two compares and two saturating increments, which load the
// result register. A new beat is taken every cycle while the result can drain.
// Reset is synchronous and clears the counters, both valid flags and the
// registers to their defaults. A stalled result holds the input register;
// the input side keeps flowing as long as the result register can drain.
`include "assert_macros.svh"

module sparse_triangle_split_pointers import stps_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [30:0] entry_index, [31] zero
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [0] has_entry, [1] last_row
  input  logic                  s_axis_tlast,   // row_end
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [30:0] row_number,
                                                // [61:31] lower_pointer,
                                                // [92:62] upper_pointer,
                                                // [123:93] lower_total,
                                                // [154:124] upper_total,
                                                // [159:155] zero
  output logic                  m_axis_tuser,   // [0] config_error
  output logic                  m_axis_tlast,   // matrix_done
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic                  cfg_data
);

  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  // Configuration registers.
  cfg_t cfg;

  // Input register.
  logic               s1_valid;
  logic [FIELD_W-1:0] s1_index;
  logic               s1_has_entry;
  logic               s1_row_end;
  logic               s1_last_row;

  // Scan state.
  logic [COUNT_BITS-1:0] row_counter;
  logic [COUNT_BITS-1:0] lower_running;
  logic [COUNT_BITS-1:0] upper_running;
  logic [COUNT_BITS-1:0] row_counter_next;
  logic [COUNT_BITS-1:0] lower_running_next;
  logic [COUNT_BITS-1:0] upper_running_next;

  // Result register.
  logic               out_valid;
  logic [FIELD_W-1:0] row_number;
  logic [FIELD_W-1:0] lower_pointer;
  logic [FIELD_W-1:0] upper_pointer;
  logic [FIELD_W-1:0] lower_total;
  logic [FIELD_W-1:0] upper_total;
  logic               config_error;
  logic               matrix_done;

  logic                  advance;
  cls_t                  cls;
  logic [COUNT_BITS-1:0] lower_count;
  logic [COUNT_BITS-1:0] upper_count;
  logic [COUNT_BITS:0]   lower_sum;
  logic [COUNT_BITS:0]   upper_sum;
  logic [COUNT_BITS-1:0] lower_ptr;
  logic [COUNT_BITS-1:0] upper_ptr;

  // The input register moves on whenever the result register is free or
  // is being emptied in this cycle, whether or not the beat closes a row.
  assign advance       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{direction_column: 1'b0, index_base: 1'b0, lower_diag_non_unit: 1'b0,
               upper_diag_non_unit: 1'b1, lower_base: 1'b0, upper_base: 1'b0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIRECTION_COLUMN:    cfg.direction_column    <= cfg_data;
        REG_INDEX_BASE:          cfg.index_base          <= cfg_data;
        REG_LOWER_DIAG_NON_UNIT: cfg.lower_diag_non_unit <= cfg_data;
        REG_UPPER_DIAG_NON_UNIT: cfg.upper_diag_non_unit <= cfg_data;
        REG_LOWER_BASE:          cfg.lower_base          <= cfg_data;
        REG_UPPER_BASE:          cfg.upper_base          <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_index     <= s_axis_tdata[FIELD_W-1:0];
      s1_has_entry <= s_axis_tuser[0];
      s1_row_end   <= s_axis_tlast;
      s1_last_row  <= s_axis_tuser[1];
    end
  end

  stps_classify #(
    .COUNT_BITS (COUNT_BITS)
  ) u_classify (
    .cfg         (cfg),
    .row_counter (row_counter),
    .entry_index (s1_index),
    .has_entry   (s1_has_entry),
    .cls         (cls)
  );

  // Counts stop at all ones. The entry of a beat is counted before the
  // row result of the same beat is formed.
  assign lower_count = (cls.inc_lower && !(&lower_running)) ? lower_running + CntOne
                                                             : lower_running;
  assign upper_count = (cls.inc_upper && !(&upper_running)) ? upper_running + CntOne
                                                             : upper_running;

  assign lower_sum = {1'b0, lower_count} + (COUNT_BITS + 1)'(cfg.lower_base);
  assign upper_sum = {1'b0, upper_count} + (COUNT_BITS + 1)'(cfg.upper_base);
  assign lower_ptr = lower_sum[COUNT_BITS] ? '1 : lower_sum[COUNT_BITS-1:0];
  assign upper_ptr = upper_sum[COUNT_BITS] ? '1 : upper_sum[COUNT_BITS-1:0];

  always_comb begin
    row_counter_next   = row_counter;
    lower_running_next = lower_count;
    upper_running_next = upper_count;
    if (s1_row_end) begin
      if (s1_last_row) begin
        row_counter_next   = '0;
        lower_running_next = '0;
        upper_running_next = '0;
      end else if (!(&row_counter)) begin
        row_counter_next = row_counter + CntOne;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter   <= '0;
      lower_running <= '0;
      upper_running <= '0;
    end else if (advance) begin
      row_counter   <= row_counter_next;
      lower_running <= lower_running_next;
      upper_running <= upper_running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_row_end;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_row_end) begin
      row_number    <= FIELD_W'(row_counter);
      lower_pointer <= FIELD_W'(lower_ptr);
      upper_pointer <= FIELD_W'(upper_ptr);
      lower_total   <= FIELD_W'(lower_count);
      upper_total   <= FIELD_W'(upper_count);
      config_error  <= cfg.lower_diag_non_unit && cfg.upper_diag_non_unit;
      matrix_done   <= s1_last_row;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - 5 * FIELD_W)'(0), upper_total, lower_total,
                          upper_pointer, lower_pointer, row_number};
  assign m_axis_tuser  = config_error;
  assign m_axis_tlast  = matrix_done;

  // An entry is never counted into both parts.
  `ASSERT_SAME(a_one_part, s1_valid, !(cls.inc_lower && cls.inc_upper),
               "entry counted into both parts")
  // Closing the last row brings every counter back to zero.
  `ASSERT_NEXT(a_last_clears, advance && s1_row_end && s1_last_row,
               row_counter == '0 && lower_running == '0 && upper_running == '0,
               "counters not cleared after last row")
  // A beat that closes a row always leaves a result behind.
  `ASSERT_NEXT(a_row_result, advance && s1_row_end, out_valid,
               "row end produced no result")
  // A beat that closes no row leaves the row counter alone.
  `ASSERT_NEXT(a_row_hold, advance && !s1_row_end, $stable(row_counter),
               "row counter moved without a row end")

endmodule

/* rtl/stps_classify.sv */
// Sorts one entry into the lower part, the upper part, or neither.
// Depends on stps_pkg for the configuration and result structs.
module stps_classify import stps_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  cfg_t                  cfg,
  input  logic [COUNT_BITS-1:0] row_counter,
  input  logic [FIELD_W-1:0]    entry_index,
  input  logic                  has_entry,
  output cls_t                  cls
);

  // One spare bit so the row plus index base never wraps.
  localparam int CmpW = ((COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W) + 1;

  logic [CmpW-1:0] row_ix;
  logic [CmpW-1:0] key;
  logic            below;
  logic            above;

  assign row_ix = CmpW'(row_counter) + CmpW'(cfg.index_base);
  assign key    = CmpW'(entry_index);
  assign below  = key < row_ix;
  assign above  = key > row_ix;

  always_comb begin
    cls = '0;
    if (has_entry) begin
      if (below) begin
        if (cfg.direction_column) cls.inc_upper = 1'b1;
        else cls.inc_lower = 1'b1;
      end else if (above) begin
        if (cfg.direction_column) cls.inc_lower = 1'b1;
        else cls.inc_upper = 1'b1;
      end else if (cfg.direction_column) begin
        // Diagonal, column grouping: the upper part has first claim.
        if (cfg.upper_diag_non_unit) cls.inc_upper = 1'b1;
        else if (cfg.lower_diag_non_unit) cls.inc_lower = 1'b1;
      end else begin
        // Diagonal, row grouping: the lower part has first claim.
        if (cfg.lower_diag_non_unit) cls.inc_lower = 1'b1;
        else if (cfg.upper_diag_non_unit) cls.inc_upper = 1'b1;
      end
    end
  end

endmodule
